### sv/tclp_pkg.sv
// ============================================================================
// tclp_pkg
// Types, codes and verb tables shared by the command line parser modules.
// ============================================================================
package tclp_pkg;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_LOSS = 1'b1;

    localparam logic VERDICT_ACCEPT = 1'b0;
    localparam logic VERDICT_REJECT = 1'b1;

    localparam logic [1:0] KIND_PING     = 2'd0;
    localparam logic [1:0] KIND_THROTTLE = 2'd1;
    localparam logic [1:0] KIND_STEER    = 2'd2;
    localparam logic [1:0] KIND_BRAKE    = 2'd3;

    // Parse phases: below PH_SIGN the phase is the position inside the verb.
    localparam logic [4:0] PH_VERB       = 5'd0;
    localparam logic [4:0] PH_SIGN       = 5'd16;
    localparam logic [4:0] PH_NEED_DIGIT = 5'd17;
    localparam logic [4:0] PH_NUMBER     = 5'd18;
    localparam logic [4:0] PH_PING_END   = 5'd19;

    localparam logic [6:0] MAX_MAGNITUDE = 7'd100;

    localparam logic [7:0] PRINT_LOW  = 8'd32;
    localparam logic [7:0] PRINT_HIGH = 8'd126;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    typedef struct packed {
        logic              verdict;
        logic [1:0]        command_kind;
        logic signed [7:0] command_value;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result res;
    } t_step;

    function automatic logic [3:0] verb_len(input logic [1:0] kind);
        logic [3:0] len;
        unique case (kind)
            KIND_PING:     len = 4'd4;
            KIND_THROTTLE: len = 4'd9;
            KIND_STEER:    len = 4'd6;
            KIND_BRAKE:    len = 4'd6;
            default:       len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] verb_char(input logic [1:0] kind, input logic [3:0] pos);
        logic [7:0] ch;
        ch = CHAR_NONE;
        unique case (kind)
            KIND_PING: begin
                case (pos)
                    4'd0:    ch = "P";
                    4'd1:    ch = "I";
                    4'd2:    ch = "N";
                    4'd3:    ch = "G";
                    default: ch = CHAR_NONE;
                endcase
            end
            KIND_THROTTLE: begin
                case (pos)
                    4'd0:    ch = "T";
                    4'd1:    ch = "H";
                    4'd2:    ch = "R";
                    4'd3:    ch = "O";
                    4'd4:    ch = "T";
                    4'd5:    ch = "T";
                    4'd6:    ch = "L";
                    4'd7:    ch = "E";
                    4'd8:    ch = " ";
                    default: ch = CHAR_NONE;
                endcase
            end
            KIND_STEER: begin
                case (pos)
                    4'd0:    ch = "S";
                    4'd1:    ch = "T";
                    4'd2:    ch = "E";
                    4'd3:    ch = "E";
                    4'd4:    ch = "R";
                    4'd5:    ch = " ";
                    default: ch = CHAR_NONE;
                endcase
            end
            KIND_BRAKE: begin
                case (pos)
                    4'd0:    ch = "B";
                    4'd1:    ch = "R";
                    4'd2:    ch = "A";
                    4'd3:    ch = "K";
                    4'd4:    ch = "E";
                    4'd5:    ch = " ";
                    default: ch = CHAR_NONE;
                endcase
            end
            default: ch = CHAR_NONE;
        endcase
        return ch;
    endfunction

endpackage

### sv/tclp_in_if.sv
// ============================================================================
// tclp_in_if
// Input channel: received byte or stream-loss event with valid/ready.
// ============================================================================
interface tclp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

### sv/tclp_out_if.sv
// ============================================================================
// tclp_out_if
// Result channel: verdict, command kind and value with valid/ready.
// ============================================================================
interface tclp_out_if;
    logic              valid;
    logic              ready;
    logic              verdict;
    logic [1:0]        command_kind;
    logic signed [7:0] command_value;

    modport source (output valid, output verdict, output command_kind,
                    output command_value, input ready);
    modport sink   (input valid, input verdict, input command_kind,
                    input command_value, output ready);
endinterface

### sv/tclp_line_parser.sv
// ============================================================================
// tclp_line_parser
// Line state and one-byte grammar step; result is combinational per step.
// ============================================================================
module tclp_line_parser #(
    parameter int LINE_BUFFER_SIZE = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_op,
    input  logic [7:0]           i_data_byte,
    output tclp_pkg::t_step      o_step
);

    localparam int LEN_W = $clog2(LINE_BUFFER_SIZE);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BUFFER_SIZE - 1);

    logic [LEN_W-1:0] r_len,   n_len;
    logic             r_disc,  n_disc;
    logic [4:0]       r_phase, n_phase;
    logic [1:0]       r_kind,  n_kind;
    logic             r_neg,   n_neg;
    logic [6:0]       r_mag,   n_mag;
    logic             r_bad,   n_bad;

    logic       w_term, w_print, w_digit, w_ok;
    logic [9:0] w_next;
    logic [1:0] w_kind_eff;
    logic       w_letter_ok;
    logic [3:0] w_vlen;
    logic [3:0] w_pos_inc;
    logic [7:0] w_value;

    assign w_term  = (i_data_byte == tclp_pkg::CHAR_CR) || (i_data_byte == tclp_pkg::CHAR_LF);
    assign w_print = (i_data_byte >= tclp_pkg::PRINT_LOW) && (i_data_byte <= tclp_pkg::PRINT_HIGH);
    assign w_digit = (i_data_byte >= tclp_pkg::CHAR_ZERO) && (i_data_byte <= tclp_pkg::CHAR_NINE);
    assign w_next  = ({3'b000, r_mag} << 3) + ({3'b000, r_mag} << 1) + {6'd0, i_data_byte[3:0]};

    always_comb begin
        w_letter_ok = 1'b1;
        w_kind_eff  = r_kind;
        if (r_phase == tclp_pkg::PH_VERB) begin
            priority case (i_data_byte)
                "P":     w_kind_eff = tclp_pkg::KIND_PING;
                "T":     w_kind_eff = tclp_pkg::KIND_THROTTLE;
                "S":     w_kind_eff = tclp_pkg::KIND_STEER;
                "B":     w_kind_eff = tclp_pkg::KIND_BRAKE;
                default: w_letter_ok = 1'b0;
            endcase
        end
    end

    assign w_vlen    = tclp_pkg::verb_len(w_kind_eff);
    assign w_pos_inc = r_phase[3:0] + 4'd1;

    assign w_ok = !r_bad
                  && (r_phase == tclp_pkg::PH_PING_END || r_phase == tclp_pkg::PH_NUMBER)
                  && (r_kind == tclp_pkg::KIND_STEER || !r_neg || r_mag == 7'd0);
    assign w_value = r_neg ? (8'd0 - {1'b0, r_mag}) : {1'b0, r_mag};

    always_comb begin
        n_len   = r_len;
        n_disc  = r_disc;
        n_phase = r_phase;
        n_kind  = r_kind;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_bad   = r_bad;
        o_step.emit              = 1'b0;
        o_step.res.verdict       = tclp_pkg::VERDICT_REJECT;
        o_step.res.command_kind  = tclp_pkg::KIND_PING;
        o_step.res.command_value = 8'sd0;

        priority if (i_op == tclp_pkg::OP_LOSS || (!w_term && !r_disc
                     && (!w_print || r_len == LEN_LAST))) begin
            n_len   = '0;
            n_phase = tclp_pkg::PH_VERB;
            n_kind  = tclp_pkg::KIND_PING;
            n_neg   = 1'b0;
            n_mag   = 7'd0;
            n_bad   = 1'b0;
            n_disc  = 1'b1;
            o_step.emit = 1'b1;
        end else if (w_term) begin
            if (!r_disc && r_len != '0) begin
                o_step.emit = 1'b1;
                if (w_ok) begin
                    o_step.res.verdict       = tclp_pkg::VERDICT_ACCEPT;
                    o_step.res.command_kind  = r_kind;
                    o_step.res.command_value = w_value;
                end
            end
            n_len   = '0;
            n_phase = tclp_pkg::PH_VERB;
            n_kind  = tclp_pkg::KIND_PING;
            n_neg   = 1'b0;
            n_mag   = 7'd0;
            n_bad   = 1'b0;
            n_disc  = 1'b0;
        end else if (r_disc) begin
            n_disc = 1'b1;
        end else begin
            n_len = r_len + 1'b1;
            if (!r_bad) begin
                priority if (!r_phase[4]) begin
                    if (r_phase == tclp_pkg::PH_VERB && w_letter_ok) begin
                        n_kind = w_kind_eff;
                    end
                    if (!w_letter_ok || r_phase[3:0] >= w_vlen
                        || tclp_pkg::verb_char(w_kind_eff, r_phase[3:0]) != i_data_byte) begin
                        n_bad = 1'b1;
                    end else if (w_pos_inc == w_vlen) begin
                        n_phase = (w_kind_eff == tclp_pkg::KIND_PING) ?
                                  tclp_pkg::PH_PING_END : tclp_pkg::PH_SIGN;
                    end else begin
                        n_phase = {1'b0, w_pos_inc};
                    end
                end else if (r_phase == tclp_pkg::PH_SIGN && i_data_byte == tclp_pkg::CHAR_MINUS) begin
                    n_neg   = 1'b1;
                    n_phase = tclp_pkg::PH_NEED_DIGIT;
                end else if (r_phase == tclp_pkg::PH_SIGN && i_data_byte == tclp_pkg::CHAR_PLUS) begin
                    n_phase = tclp_pkg::PH_NEED_DIGIT;
                end else if ((r_phase == tclp_pkg::PH_SIGN || r_phase == tclp_pkg::PH_NEED_DIGIT
                              || r_phase == tclp_pkg::PH_NUMBER) && w_digit) begin
                    if (w_next > {3'b000, tclp_pkg::MAX_MAGNITUDE}) begin
                        n_bad = 1'b1;
                    end else begin
                        n_mag   = w_next[6:0];
                        n_phase = tclp_pkg::PH_NUMBER;
                    end
                end else begin
                    n_bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_disc  <= 1'b0;
            r_phase <= tclp_pkg::PH_VERB;
            r_kind  <= tclp_pkg::KIND_PING;
            r_neg   <= 1'b0;
            r_mag   <= 7'd0;
            r_bad   <= 1'b0;
        end else if (i_step) begin
            r_len   <= n_len;
            r_disc  <= n_disc;
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_bad   <= n_bad;
        end
    end

endmodule

### sv/text_command_line_parser.sv
// ============================================================================
// text_command_line_parser
// Byte-at-a-time parser for CR/LF-terminated PING/THROTTLE/STEER/BRAKE lines.
// ============================================================================
// One byte or stream-loss event is taken per clock cycle. Each transaction
// lands in an input register, is parsed against the current line state in the
// same cycle it leaves that register, and any verdict is held in a result
// register. The only limit on rate is the result register: while it holds a
// verdict that the sink has not taken, the pipeline stalls; otherwise a new
// transaction is accepted every cycle.
module text_command_line_parser #(
    parameter int LINE_BUFFER_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tclp_in_if.sink     i_cmd,
    tclp_out_if.source  o_res
);

    logic              r_in_valid;
    logic              r_in_op;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    tclp_pkg::t_result r_out;

    logic            w_adv;
    logic            w_step;
    tclp_pkg::t_step w_result;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign w_step      = r_in_valid && w_adv;
    assign i_cmd.ready = !r_in_valid || w_adv;

    tclp_line_parser #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_op        (r_in_op),
        .i_data_byte (r_in_byte),
        .o_step      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.valid && i_cmd.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid && i_cmd.ready) begin
            r_in_op   <= i_cmd.op;
            r_in_byte <= i_cmd.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_result.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_result.emit) begin
            r_out <= w_result.res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.verdict       = r_out.verdict;
    assign o_res.command_kind  = r_out.command_kind;
    assign o_res.command_value = r_out.command_value;

endmodule
